// ===== rtl/core/k_of_n_combination_enumerator_unit_macros.svh =====
// assertion macros for the k-of-n combination enumerator
// used by the top level only, no other dependencies
`ifndef K_OF_N_COMBINATION_ENUMERATOR_UNIT_MACROS_SVH
`define K_OF_N_COMBINATION_ENUMERATOR_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define KOCEN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define KOCEN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/core/kocen_pkg.sv =====
// shared types, codes and the microcode table of the combination enumerator
// no dependencies
package kocen_pkg;

	localparam int CMD_W             = 2;
	localparam int IDX_W             = 5;
	localparam int POS_W             = 5;
	localparam int CFG_W             = 6;
	localparam int CFG_IDX_W         = 1;
	localparam int PC_W              = 3;
	localparam int DEF_MAX_ELEMENTS  = 32;
	localparam int DEF_ELEMENT_WIDTH = 8;

	localparam logic [CFG_W-1:0] SET_SIZE_RST     = 6'd5;
	localparam logic [CFG_W-1:0] CHOOSE_COUNT_RST = 6'd3;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_RESTART = 2'd1,
		CMD_EMIT    = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SET_SIZE     = 1'b0,
		REG_CHOOSE_COUNT = 1'b1
	} cfg_reg_t;

	// datapath operation selected by the current step
	typedef enum logic [2:0] {
		U_NOP,
		U_IDLE,
		U_INIT,
		U_SCAN,
		U_ADV,
		U_EXH,
		U_EMPTY
	} uop_t;

	// jump condition of a step
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_EMIT_ACC,
		C_DONE,
		C_K_ZERO,
		C_SCAN_END,
		C_OUT_FREE
	} cond_t;

	// what the step counter does when the jump is not taken
	typedef enum logic {
		SQ_HOLD,
		SQ_NEXT
	} seq_t;

	typedef struct packed {
		uop_t            uop;
		cond_t           cond;
		seq_t            els;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic emit_acc;
		logic done;
		logic k_zero;
		logic scan_end;
		logic out_free;
	} status_t;

	localparam logic [PC_W-1:0] PC_IDLE      = 3'd0;
	localparam logic [PC_W-1:0] PC_INIT      = 3'd1;
	localparam logic [PC_W-1:0] PC_CHK_EMPTY = 3'd2;
	localparam logic [PC_W-1:0] PC_SCAN      = 3'd3;
	localparam logic [PC_W-1:0] PC_ADV       = 3'd4;
	localparam logic [PC_W-1:0] PC_EXH       = 3'd5;
	localparam logic [PC_W-1:0] PC_EMPTY     = 3'd6;

	function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			PC_IDLE:      w = '{U_IDLE,  C_EMIT_ACC, SQ_HOLD, PC_INIT};
			PC_INIT:      w = '{U_INIT,  C_DONE,     SQ_NEXT, PC_EXH};
			PC_CHK_EMPTY: w = '{U_NOP,   C_K_ZERO,   SQ_NEXT, PC_EMPTY};
			PC_SCAN:      w = '{U_SCAN,  C_SCAN_END, SQ_HOLD, PC_ADV};
			PC_ADV:       w = '{U_ADV,   C_ALWAYS,   SQ_HOLD, PC_IDLE};
			PC_EXH:       w = '{U_EXH,   C_OUT_FREE, SQ_HOLD, PC_IDLE};
			PC_EMPTY:     w = '{U_EMPTY, C_OUT_FREE, SQ_HOLD, PC_ADV};
			default:      w = '{U_NOP,   C_ALWAYS,   SQ_HOLD, PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/kocen_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module kocen_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/kocen_seq.sv =====
// microcode sequencer: step counter, control table lookup, conditional jumps
// depends on kocen_pkg
module kocen_seq import kocen_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output uop_t    uop
);

	logic [PC_W-1:0] pc_q;
	uword_t          word;
	logic            take;

	assign word = ucode_rom(pc_q);
	assign uop  = word.uop;

	always_comb begin
		case (word.cond)
			C_ALWAYS:   take = 1'b1;
			C_EMIT_ACC: take = status.emit_acc;
			C_DONE:     take = status.done;
			C_K_ZERO:   take = status.k_zero;
			C_SCAN_END: take = status.scan_end;
			C_OUT_FREE: take = status.out_free;
			default:    take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else if (take) begin
			pc_q <= word.target;
		end else if (word.els == SQ_NEXT) begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

// ===== rtl/core/kocen_dp.sv =====
// datapath: config registers, selection mask, scan counters, element store, output word
// depends on kocen_pkg and kocen_ram
module kocen_dp import kocen_pkg::*; #(
	parameter int MAX_ELEMENTS  = DEF_MAX_ELEMENTS,
	parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  uop_t                     uop,
	output status_t                  status,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic [ELEMENT_WIDTH-1:0] element_value,
	input  logic [IDX_W-1:0]         element_index,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ELEMENT_WIDTH-1:0] element_value_res,
	output logic [POS_W-1:0]         element_position,
	output logic                     last,
	output logic                     empty_combination,
	output logic                     exhausted
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int AW    = $clog2(MAX_ELEMENTS);
	localparam int NW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	function automatic logic [MAX_ELEMENTS-1:0] low_ones(logic [CNT_W-1:0] cnt);
		return ~({MAX_ELEMENTS{1'b1}} << cnt);
	endfunction

	function automatic logic [CNT_W-1:0] eff_n(logic [CFG_W-1:0] sz);
		logic [NW-1:0] s;
		s = NW'(sz);
		return (s > NW'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS) : CNT_W'(s);
	endfunction

	function automatic logic [CNT_W-1:0] eff_k(logic [CFG_W-1:0] sz, logic [CFG_W-1:0] ck);
		logic [CNT_W-1:0] n;
		logic [NW-1:0]    c;
		n = eff_n(sz);
		c = NW'(ck);
		return (c > NW'(n)) ? n : CNT_W'(c);
	endfunction

	localparam logic [MAX_ELEMENTS-1:0] MASK_RST =
		low_ones(eff_k(SET_SIZE_RST, CHOOSE_COUNT_RST));

	logic [CFG_W-1:0]         set_size_q, choose_count_q;
	logic [CFG_W-1:0]         set_size_nx, choose_count_nx;
	logic [MAX_ELEMENTS-1:0]  mask_q;
	logic                     done_q;
	logic [CNT_W-1:0]         i_q, ones_q, rem_q, found_pos_q, found_ones_q;
	logic                     found_q;
	logic                     out_valid_q;
	logic [POS_W-1:0]         out_pos_q;
	logic                     out_last_q, out_empty_q, out_exh_q, out_zero_q;

	logic [CNT_W-1:0]         n_eff, k_eff, i_inc, fp_inc;
	logic [MAX_ELEMENTS-1:0]  shifted, restart_mask, adv_mask;
	logic                     here, above, pair;
	logic                     out_free, in_acc, cfg_acc, restart;
	logic                     scan_live, scan_emit, scan_step;
	logic                     wr_en;
	logic [ELEMENT_WIDTH-1:0] rd_data;

	assign n_eff    = eff_n(set_size_q);
	assign k_eff    = eff_k(set_size_q, choose_count_q);
	assign out_free = !out_valid_q || out_ready;

	assign in_ready  = (uop == U_IDLE);
	assign cfg_ready = (uop == U_IDLE) && !in_valid;
	assign in_acc    = in_valid && in_ready;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign restart   = cfg_acc || (in_acc && (command == CMD_RESTART));

	always_comb begin
		set_size_nx     = set_size_q;
		choose_count_nx = choose_count_q;
		if (cfg_acc) begin
			case (cfg_index)
				REG_SET_SIZE:     set_size_nx     = cfg_data;
				REG_CHOOSE_COUNT: choose_count_nx = cfg_data;
				default: ;
			endcase
		end
	end

	// a config write restarts with the sizes it has just written
	assign restart_mask = low_ones(eff_k(set_size_nx, choose_count_nx));

	// one mask position per scan step
	assign shifted   = mask_q >> i_q;
	assign here      = shifted[0];
	assign above     = shifted[1];
	assign i_inc     = i_q + 1'b1;
	assign pair      = here && !above && (i_inc != n_eff);
	assign scan_live = (uop == U_SCAN) && (i_q != n_eff);
	assign scan_emit = scan_live && here && out_free;
	assign scan_step = scan_live && (!here || out_free);

	// swap the found 10 pair and pack the lower ones down to bit 0
	assign fp_inc   = found_pos_q + 1'b1;
	assign adv_mask = (mask_q & ~low_ones(fp_inc))
		| ({{(MAX_ELEMENTS-1){1'b0}}, 1'b1} << fp_inc)
		| low_ones(found_ones_q);

	assign wr_en = in_acc && (command == CMD_LOAD) && (32'(element_index) < MAX_ELEMENTS);

	kocen_ram #(
		.WIDTH (ELEMENT_WIDTH),
		.DEPTH (MAX_ELEMENTS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(element_index)),
		.wr_data (element_value),
		.rd_en   (scan_emit),
		.rd_addr (i_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign status.emit_acc = in_acc && (command == CMD_EMIT);
	assign status.done     = done_q;
	assign status.k_zero   = (k_eff == '0);
	assign status.scan_end = (i_q == n_eff);
	assign status.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q     <= SET_SIZE_RST;
			choose_count_q <= CHOOSE_COUNT_RST;
			mask_q         <= MASK_RST;
			done_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			i_q            <= '0;
			ones_q         <= '0;
			rem_q          <= '0;
			found_q        <= 1'b0;
			found_pos_q    <= '0;
			found_ones_q   <= '0;
		end else begin
			set_size_q     <= set_size_nx;
			choose_count_q <= choose_count_nx;
			if (restart) begin
				mask_q <= restart_mask;
				done_q <= 1'b0;
			end
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (uop)
				U_INIT: begin
					i_q     <= '0;
					ones_q  <= '0;
					rem_q   <= k_eff;
					found_q <= 1'b0;
				end
				U_SCAN: begin
					if (scan_step) begin
						i_q <= i_inc;
						if (here) begin
							rem_q       <= rem_q - 1'b1;
							out_valid_q <= 1'b1;
						end
						if (!found_q) begin
							if (pair) begin
								found_q      <= 1'b1;
								found_pos_q  <= i_q;
								found_ones_q <= ones_q;
							end else if (here) begin
								ones_q <= ones_q + 1'b1;
							end
						end
					end
				end
				U_ADV: begin
					if (found_q) begin
						mask_q <= adv_mask;
					end else begin
						done_q <= 1'b1;
					end
				end
				U_EXH, U_EMPTY: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// output word fields, the value itself sits in the store's read register
	always_ff @(posedge clk) begin
		if (scan_emit) begin
			out_pos_q   <= POS_W'(i_q);
			out_last_q  <= (rem_q == CNT_W'(1));
			out_empty_q <= 1'b0;
			out_exh_q   <= 1'b0;
			out_zero_q  <= 1'b0;
		end else if ((uop == U_EXH) && out_free) begin
			out_pos_q   <= '0;
			out_last_q  <= 1'b1;
			out_empty_q <= 1'b0;
			out_exh_q   <= 1'b1;
			out_zero_q  <= 1'b1;
		end else if ((uop == U_EMPTY) && out_free) begin
			out_pos_q   <= '0;
			out_last_q  <= 1'b1;
			out_empty_q <= 1'b1;
			out_exh_q   <= 1'b0;
			out_zero_q  <= 1'b1;
		end
	end

	assign out_valid         = out_valid_q;
	assign element_value_res = out_zero_q ? '0 : rd_data;
	assign element_position  = out_pos_q;
	assign last              = out_last_q;
	assign empty_combination = out_empty_q;
	assign exhausted         = out_exh_q;

endmodule

// ===== rtl/core/k_of_n_combination_enumerator_unit.sv =====
// top level of the k-of-n combination enumerator: sequencer plus datapath
// depends on kocen_pkg, kocen_seq, kocen_dp and the assertion macro header
//
// Input channel (in_valid/in_ready) takes one command word: load an element into
// the store, restart the enumeration, or emit the current combination and advance.
// Config channel (cfg_valid/cfg_ready) writes set_size (index 0) or choose_count
// (index 1); each write also restarts the enumeration. Config is taken only while
// the block is idle and no input word is offered.
// Load and restart are done as the word is accepted. An emit word, for n elements
// in use, holds the input through the accepting cycle, one init step, one check
// step, one scan step per mask position plus a closing one (the mask is walked one
// bit a cycle unless a selected bit waits for the output, reading the element
// store through its single read port), then one step to advance the mask. Each
// selected element appears on the output in the cycle after its scan step; an
// exhausted result runs an exhausted step after init, an empty one an empty step.
// The output word is held in a register: a stalled receiver freezes the scan at
// the next selected element, and the next input word is accepted while the last
// result still waits. At reset n = 5 and k = 3, the mask holds the lowest three
// positions and the element store is undefined until loaded; no clearing pass.
`include "k_of_n_combination_enumerator_unit_macros.svh"

module k_of_n_combination_enumerator_unit import kocen_pkg::*; #(
	parameter int MAX_ELEMENTS  = DEF_MAX_ELEMENTS,
	parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic [ELEMENT_WIDTH-1:0] element_value,
	input  logic [IDX_W-1:0]         element_index,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [ELEMENT_WIDTH-1:0] element_value_res,
	output logic [POS_W-1:0]         element_position,
	output logic                     last,
	output logic                     empty_combination,
	output logic                     exhausted
);

	uop_t    uop;
	status_t status;

	kocen_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.uop    (uop)
	);

	kocen_dp #(
		.MAX_ELEMENTS  (MAX_ELEMENTS),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.uop               (uop),
		.status            (status),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.command           (command),
		.element_value     (element_value),
		.element_index     (element_index),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.element_value_res (element_value_res),
		.element_position  (element_position),
		.last              (last),
		.empty_combination (empty_combination),
		.exhausted         (exhausted)
	);

	// an emit word holds off further input until its program has run
	`KOCEN_ASSERT_NEXT(a_emit_blocks_input, clk, arst_n, in_valid && in_ready && (command == CMD_EMIT), !in_ready)
	// a finished scan always goes on to the mask advance
	`KOCEN_ASSERT_NEXT(a_scan_end_advances, clk, arst_n, (uop == U_SCAN) && status.scan_end, uop == U_ADV)
	// marker results carry no element and close the word
	`KOCEN_ASSERT_SAME(a_marker_word_clear, clk, arst_n, out_valid && (exhausted || empty_combination), last && (element_value_res == '0) && (element_position == '0))

endmodule
